// File: src/xae_pkg.sv
// Shared types and character codes for the XML attribute escaper.
package xae_pkg;

    typedef enum logic [2:0] {
        K_PLAIN,
        K_AMP,
        K_LT,
        K_APOS,
        K_QUOT,
        K_HEX
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
    } t_desc;

    typedef struct packed {
        logic upper;
        logic pad;
    } t_cfg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

endpackage

// File: src/xae_front.sv
// Front end: accepts raw bytes, classifies them and tracks the space flag.
module xae_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [7:0]     i_in_byte,
    input  logic           i_last_of_buffer,
    input  logic           i_full,
    output logic           o_in_stall,
    output logic           o_push,
    output xae_pkg::t_desc o_desc
);
    import xae_pkg::*;

    logic  r_space_seen;
    logic  n_space_seen;
    t_kind kind;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid & ~i_full;

    always_comb begin
        kind         = K_PLAIN;
        n_space_seen = r_space_seen;
        priority if (i_in_byte == CH_AMP) begin
            kind = K_AMP;
        end else if (i_in_byte == CH_LT) begin
            kind = K_LT;
        end else if (i_in_byte == CH_APOS) begin
            kind = K_APOS;
        end else if (i_in_byte == CH_QUOT) begin
            kind = K_QUOT;
        end else if (i_in_byte[7] || i_in_byte == CH_CR || i_in_byte == CH_LF
                     || i_in_byte == CH_TAB) begin
            kind = K_HEX;
        end else if (i_in_byte == CH_SPACE) begin
            if (r_space_seen) begin
                kind = K_HEX;
            end else begin
                n_space_seen = 1'b1;
            end
        end else begin
            n_space_seen = 1'b0;
        end
    end

    assign o_desc = '{kind: kind, data: i_in_byte, last: i_last_of_buffer};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_seen <= 1'b0;
        end else if (o_push) begin
            r_space_seen <= n_space_seen;
        end
    end

endmodule

// File: src/xae_fifo.sv
// Short descriptor queue between front and back ends.
module xae_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xae_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output xae_pkg::t_desc o_desc
);
    import xae_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [AW:0]   r_wptr;
    logic [AW:0]   r_rptr;

    assign o_valid = r_wptr != r_rptr;
    assign o_full  = (r_wptr[AW] != r_rptr[AW]) && (r_wptr[AW-1:0] == r_rptr[AW-1:0]);
    assign o_desc  = r_mem[r_rptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr[AW-1:0]] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) <= DEPTH_V)
        else $error("queue fill out of range");
`endif

endmodule

// File: src/xae_back.sv
// Back end: expands one descriptor into its escaped byte run.
module xae_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  xae_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  xae_pkg::t_desc i_desc,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_item,
    output logic           o_buffer_done
);
    import xae_pkg::*;

    localparam logic [5:0][7:0] TXT_AMP  = {"&amp;", 8'h00};
    localparam logic [5:0][7:0] TXT_LT   = {"&lt;", 16'h0000};
    localparam logic [5:0][7:0] TXT_APOS = "&apos;";
    localparam logic [5:0][7:0] TXT_QUOT = "&quot;";

    logic [2:0]      r_idx;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_last_of_item;
    logic            r_buffer_done;

    logic            advance;
    logic            fin;
    logic            two_dig;
    logic [2:0]      len;
    logic [7:0]      hex_hi;
    logic [7:0]      hex_lo;
    logic [5:0][7:0] txt;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? 8'h41 : 8'h61;
        if (nib < 4'd10) begin
            return 8'h30 + {4'b0000, nib};
        end
        return base + {4'b0000, nib} - 8'd10;
    endfunction

    assign two_dig = i_cfg.pad || (i_desc.data[7:4] != 4'd0);
    assign hex_hi  = hex_char(i_desc.data[7:4], i_cfg.upper);
    assign hex_lo  = hex_char(i_desc.data[3:0], i_cfg.upper);

    always_comb begin
        unique case (i_desc.kind)
            K_PLAIN: begin
                txt = {i_desc.data, 40'h0};
                len = 3'd1;
            end
            K_AMP: begin
                txt = TXT_AMP;
                len = 3'd5;
            end
            K_LT: begin
                txt = TXT_LT;
                len = 3'd4;
            end
            K_APOS: begin
                txt = TXT_APOS;
                len = 3'd6;
            end
            K_QUOT: begin
                txt = TXT_QUOT;
                len = 3'd6;
            end
            K_HEX: begin
                if (two_dig) begin
                    txt = {"&#x", hex_hi, hex_lo, ";"};
                    len = 3'd6;
                end else begin
                    txt = {"&#x", hex_lo, ";", 8'h00};
                    len = 3'd5;
                end
            end
            default: begin
                txt = '0;
                len = 3'd1;
            end
        endcase
    end

    assign advance = i_valid && (!r_out_valid || !i_out_stall);
    assign fin     = r_idx == (len - 3'd1);
    assign o_pop   = advance && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= fin ? 3'd0 : r_idx + 3'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte     <= txt[3'(3'd5 - r_idx)];
            r_last_of_item <= fin;
            r_buffer_done  <= fin && i_desc.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_item = r_last_of_item;
    assign o_buffer_done  = r_buffer_done;

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd5)
        else $error("byte index out of range");
    a_mid_item_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> i_valid)
        else $error("queue head lost in the middle of an item");
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_buffer_done) |-> r_last_of_item)
        else $error("buffer done off the final byte of an item");
`endif

endmodule

// File: src/xml_attribute_escaper.sv
// Top level of the XML attribute value escaper.
// Each accepted byte becomes a run of one to six output beats: a plain byte
// gives one byte, an entity or hex reference four to six, sent one per cycle
// while the output is not stalled. The front end takes a new byte every cycle
// while the descriptor queue (QUEUE_DEPTH entries, a power of two) has room,
// so plain bytes stream at one beat per cycle when the output is not stalled
// and escapes set the pace only when the queue fills. An input byte is
// registered in the queue, then in the output register. The user must write
// register 0 (hex_uppercase, address 0) and register 1 (hex_pad_two,
// address 4) only while the block is idle; the block does not enforce this.
module xml_attribute_escaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_item,
    output logic        o_buffer_done
);
    import xae_pkg::*;

    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_PAD   = 1'b1;

    logic  r_upper;
    logic  r_pad;
    logic  cfg_wr;
    logic  push;
    logic  pop;
    logic  full;
    logic  q_valid;
    t_desc f_desc;
    t_desc q_desc;
    t_cfg  cfg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= 1'b1;
            r_pad   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_UPPER: r_upper <= pwdata[0];
                REG_PAD:   r_pad   <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign prdata = {31'd0, (paddr[2] == REG_PAD) ? r_pad : r_upper};
    assign cfg    = '{upper: r_upper, pad: r_pad};

    xae_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_last_of_buffer(i_last_of_buffer),
        .i_full          (full),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_desc          (f_desc)
    );

    xae_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_desc (f_desc),
        .i_pop  (pop),
        .o_full (full),
        .o_valid(q_valid),
        .o_desc (q_desc)
    );

    xae_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (q_valid),
        .i_desc        (q_desc),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_item(o_last_of_item),
        .o_buffer_done (o_buffer_done)
    );

endmodule

// File: sim/xml_attribute_escaper_tb.sv
// Testbench for the XML attribute escaper: random and directed bytes checked against a predictor.
`timescale 1ns / 1ps

module xml_attribute_escaper_tb;
    import xae_pkg::*;

    localparam logic [2:0] ADDR_HEX_UPPER = 3'd0;
    localparam logic [2:0] ADDR_HEX_PAD   = 3'd4;
    localparam int PHASE_BYTES = 52;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       done;
    } t_beat;

    class escape_scoreboard;
        t_beat      pending[$];
        logic [7:0] run[$];
        bit         upper = 1'b1;
        bit         pad = 1'b0;
        bit         space_seen = 1'b0;
        int         errors = 0;

        function void append_text(string s);
            for (int i = 0; i < s.len(); i++) begin
                run.push_back(s[i]);
            end
        endfunction

        function logic [7:0] hex_char(logic [3:0] v);
            if (v < 4'd10) begin
                return 8'h30 + {4'd0, v};
            end
            return (upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
        endfunction

        function void append_hex_ref(logic [7:0] b);
            append_text("&#x");
            if (b[7:4] != 4'd0 || pad) begin
                run.push_back(hex_char(b[7:4]));
            end
            run.push_back(hex_char(b[3:0]));
            run.push_back(8'h3B);
        endfunction

        function void note_input(logic [7:0] b, logic buf_last);
            int n;
            run.delete();
            if (b == CH_AMP) begin
                append_text("&amp;");
            end else if (b == CH_LT) begin
                append_text("&lt;");
            end else if (b == CH_APOS) begin
                append_text("&apos;");
            end else if (b == CH_QUOT) begin
                append_text("&quot;");
            end else if (b[7] || b == CH_CR || b == CH_LF || b == CH_TAB) begin
                append_hex_ref(b);
            end else if (b == CH_SPACE) begin
                if (space_seen) begin
                    append_hex_ref(b);
                end else begin
                    space_seen = 1'b1;
                    run.push_back(b);
                end
            end else begin
                space_seen = 1'b0;
                run.push_back(b);
            end
            n = run.size();
            for (int k = 0; k < n; k++) begin
                pending.push_back({run[k], k == n - 1, (k == n - 1) && buf_last});
            end
        endfunction

        function void check_beat(logic [7:0] data, logic fin, logic done);
            t_beat want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat byte %h last %b done %b", $time, data, fin, done);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data !== want.data) begin
                $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
                errors++;
            end
            if (fin !== want.fin) begin
                $display("%0t: last_of_item expected %b actual %b", $time, want.fin, fin);
                errors++;
            end
            if (done !== want.done) begin
                $display("%0t: buffer_done expected %b actual %b", $time, want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_last_of_buffer;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_last_of_item;
    logic        o_buffer_done;

    escape_scoreboard sb;
    t_idle            idle_mode;

    xml_attribute_escaper uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_last_of_buffer(i_last_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last_of_item  (o_last_of_item),
        .o_buffer_done   (o_buffer_done)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit send_idle();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 53;
            IDLE_BOTH: return $urandom_range(99) < 13;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < 53;
            IDLE_BOTH: return $urandom_range(99) < 13;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) begin
            case ($urandom_range(7))
                0: return CH_AMP;
                1: return CH_LT;
                2: return CH_APOS;
                3: return CH_QUOT;
                4: return CH_CR;
                5: return CH_LF;
                6: return CH_TAB;
                default: return CH_SPACE;
            endcase
        end else if (sel < 45) begin
            return CH_SPACE;
        end else if (sel < 55) begin
            return 8'($urandom_range(31));
        end
        return 8'($urandom_range(255));
    endfunction

    // valid stays high across back-to-back beats; it only drops in a gap
    task automatic send_beat(input logic [7:0] b, input logic buf_last);
        while (send_idle()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_in_byte        <= b;
        i_last_of_buffer <= buf_last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(b, buf_last);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input bit value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= ($urandom() & 32'hFFFF_FFFE) | {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_HEX_UPPER) begin
            sb.upper = value;
        end else begin
            sb.pad = value;
        end
    endtask

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_beat(o_out_byte, o_last_of_item, o_buffer_done);
            end
            i_out_stall <= recv_stall();
        end
    end

    initial begin
        logic [7:0] directed_bytes[$];
        logic       directed_last[$];

        sb = new();
        idle_mode = IDLE_NONE;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_in_byte        <= '0;
        i_last_of_buffer <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // entities, hex refs, byte extremes, space runs across escapes
        directed_bytes = {CH_AMP, CH_LT, CH_APOS, CH_QUOT, CH_CR, CH_LF, CH_TAB,
                          8'h00, 8'h7F, 8'h80, 8'hFF, 8'hAB, CH_SPACE, CH_SPACE,
                          CH_SPACE, 8'h61, CH_SPACE, CH_AMP, CH_SPACE, 8'hC3,
                          CH_SPACE, 8'h62, CH_TAB};
        directed_last  = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, 1'b1, 1'b1};
        foreach (directed_bytes[i]) begin
            send_beat(directed_bytes[i], directed_last[i]);
        end
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            write_reg(ADDR_HEX_UPPER, phase[0]);
            write_reg(ADDR_HEX_PAD, phase[1]);
            idle_mode = t_idle'((phase / 2) % 4);
            for (int i = 0; i < PHASE_BYTES; i++) begin
                send_beat(pick_byte(), $urandom_range(7) == 0);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
